/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define QW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion checked at every edge, reset included
`define QW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/qwvr_pkg.sv */
// Shared types, constants and quarter-wave sine table for the vector rotator
`timescale 1ns / 1ps
`default_nettype none

package qwvr_pkg;

    localparam int unsigned VEC_W   = 16;
    localparam int unsigned ANGLE_W = 8;
    localparam int unsigned MAG_W   = 8;
    localparam int unsigned IDX_W   = 7;

    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 8'h40;
    localparam logic [IDX_W-1:0]   HALF_TURN    = 7'h40;
    localparam logic [VEC_W-1:0]   ROUND_HALF   = 16'h0080;

    localparam logic OP_ROTATE     = 1'b0;
    localparam logic OP_ROTATE_NEG = 1'b1;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } t_trig;

    function automatic logic [MAG_W-1:0] qwvr_quarter_sine(input logic [IDX_W-1:0] idx);
        logic [MAG_W-1:0] v;
        unique case (idx)
            7'd0:  v = 8'h00; 7'd1:  v = 8'h06; 7'd2:  v = 8'h0D; 7'd3:  v = 8'h13;
            7'd4:  v = 8'h19; 7'd5:  v = 8'h1F; 7'd6:  v = 8'h26; 7'd7:  v = 8'h2C;
            7'd8:  v = 8'h32; 7'd9:  v = 8'h38; 7'd10: v = 8'h3E; 7'd11: v = 8'h44;
            7'd12: v = 8'h4A; 7'd13: v = 8'h50; 7'd14: v = 8'h56; 7'd15: v = 8'h5C;
            7'd16: v = 8'h62; 7'd17: v = 8'h68; 7'd18: v = 8'h6D; 7'd19: v = 8'h73;
            7'd20: v = 8'h79; 7'd21: v = 8'h7E; 7'd22: v = 8'h84; 7'd23: v = 8'h89;
            7'd24: v = 8'h8E; 7'd25: v = 8'h93; 7'd26: v = 8'h98; 7'd27: v = 8'h9D;
            7'd28: v = 8'hA2; 7'd29: v = 8'hA7; 7'd30: v = 8'hAC; 7'd31: v = 8'hB1;
            7'd32: v = 8'hB5; 7'd33: v = 8'hB9; 7'd34: v = 8'hBE; 7'd35: v = 8'hC2;
            7'd36: v = 8'hC6; 7'd37: v = 8'hCA; 7'd38: v = 8'hCE; 7'd39: v = 8'hD1;
            7'd40: v = 8'hD5; 7'd41: v = 8'hD8; 7'd42: v = 8'hDC; 7'd43: v = 8'hDF;
            7'd44: v = 8'hE2; 7'd45: v = 8'hE5; 7'd46: v = 8'hE7; 7'd47: v = 8'hEA;
            7'd48: v = 8'hED; 7'd49: v = 8'hEF; 7'd50: v = 8'hF1; 7'd51: v = 8'hF3;
            7'd52: v = 8'hF5; 7'd53: v = 8'hF7; 7'd54: v = 8'hF8; 7'd55: v = 8'hFA;
            7'd56: v = 8'hFB; 7'd57: v = 8'hFC; 7'd58: v = 8'hFD; 7'd59: v = 8'hFE;
            7'd60: v = 8'hFF; 7'd61: v = 8'hFF; 7'd62: v = 8'hFF; 7'd63: v = 8'hFF;
            7'd64: v = 8'hFF;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic t_trig qwvr_sine(input logic [ANGLE_W-1:0] ang);
        logic [IDX_W-1:0] a;
        t_trig            t;
        a = ang[IDX_W-1:0];
        if (a >= HALF_TURN[IDX_W-1:0] - 7'd0 && a[IDX_W-1]) begin
            a = 7'd0 - a;
        end
        t.mag = qwvr_quarter_sine(a);
        t.neg = ang[ANGLE_W-1];
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/qwvr_scale.sv */
// Sign-magnitude product of a 16-bit signed component and an 8-bit factor with sign
`timescale 1ns / 1ps
`default_nettype none

module qwvr_scale
    import qwvr_pkg::*;
(
    input  wire logic [VEC_W-1:0] i_v,
    input  wire t_trig            i_f,
    output logic      [VEC_W-1:0] o_p
);

    logic             v_neg;
    logic [VEC_W-1:0] v_mag;
    logic [VEC_W-1:0] lo_prod;
    logic [VEC_W-1:0] hi_prod;
    logic [VEC_W-1:0] lo_rnd;
    logic [VEC_W-1:0] mag_sum;

    assign v_neg   = i_v[VEC_W-1];
    assign v_mag   = v_neg ? (16'd0 - i_v) : i_v;
    assign lo_prod = v_mag[MAG_W-1:0] * i_f.mag;
    assign hi_prod = v_mag[VEC_W-1:MAG_W] * i_f.mag;
    assign lo_rnd  = (lo_prod + ROUND_HALF) >> MAG_W;
    assign mag_sum = hi_prod + lo_rnd;
    assign o_p     = (v_neg != i_f.neg) ? (16'd0 - mag_sum) : mag_sum;

endmodule

`default_nettype wire

/* rtl/core/quarter_wave_vector_rotator.sv */
// Top level: 2-D vector rotation by an 8-bit angle using a quarter-wave sine table
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one transaction: i_opcode,
//   i_x_in, i_y_in, i_angle. Opcode OP_ROTATE rotates by the angle, OP_ROTATE_NEG
//   by the negated angle. Output channel (o_out_valid / i_out_ready) carries
//   o_x_out and o_y_out, each wrapping modulo 2^16.
//   Path: a transaction accepted is captured in the input register, passes the
//   table lookup, four 16x8 sign-magnitude products and the adders, and lands in
//   the result register when that register is empty or its result is being
//   taken; o_out_valid then goes high and the result can be taken.
//   Throughput: one transaction per cycle while i_out_ready stays high, set by the
//   single combinational pass between the input register and the result register.
//   Stall: when i_out_ready is low the result holds; the input register still
//   takes one more transaction if empty, then o_in_ready drops until the result
//   is taken.
//   Reset: i_rst_n low synchronously empties both registers; no transaction is
//   in flight after reset; the data registers themselves are not reset.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module quarter_wave_vector_rotator
    import qwvr_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic                      i_opcode,
    input  wire logic signed [VEC_W-1:0]   i_x_in,
    input  wire logic signed [VEC_W-1:0]   i_y_in,
    input  wire logic        [ANGLE_W-1:0] i_angle,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic signed      [VEC_W-1:0]   o_x_out,
    output logic signed      [VEC_W-1:0]   o_y_out
);

    logic               r_s1_valid;
    logic               n_s1_valid;
    logic               r_opcode;
    logic [VEC_W-1:0]   r_x;
    logic [VEC_W-1:0]   r_y;
    logic [ANGLE_W-1:0] r_angle;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [VEC_W-1:0]   r_x_out;
    logic [VEC_W-1:0]   r_y_out;

    logic               s1_advance;
    logic               in_accept;
    logic [ANGLE_W-1:0] eff_angle;
    t_trig              sin_t;
    t_trig              cos_t;
    t_trig              nsin_t;
    logic [VEC_W-1:0]   x_cos;
    logic [VEC_W-1:0]   y_sin;
    logic [VEC_W-1:0]   x_nsin;
    logic [VEC_W-1:0]   y_cos;

    assign s1_advance = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_advance;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_accept) begin
            n_s1_valid = 1'b1;
        end else if (s1_advance) begin
            n_s1_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (s1_advance) begin
            n_out_valid = r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_opcode <= i_opcode;
            r_x      <= i_x_in;
            r_y      <= i_y_in;
            r_angle  <= i_angle;
        end
    end

    assign eff_angle = (r_opcode == OP_ROTATE_NEG) ? (8'd0 - r_angle) : r_angle;
    assign sin_t     = qwvr_sine(eff_angle);
    assign cos_t     = qwvr_sine(eff_angle + QUARTER_TURN);
    assign nsin_t    = '{mag: sin_t.mag, neg: !sin_t.neg};

    qwvr_scale u_x_cos  (.i_v(r_x), .i_f(cos_t),  .o_p(x_cos));
    qwvr_scale u_y_sin  (.i_v(r_y), .i_f(sin_t),  .o_p(y_sin));
    qwvr_scale u_x_nsin (.i_v(r_x), .i_f(nsin_t), .o_p(x_nsin));
    qwvr_scale u_y_cos  (.i_v(r_y), .i_f(cos_t),  .o_p(y_cos));

    always_ff @(posedge i_clk) begin
        if (s1_advance && r_s1_valid) begin
            r_x_out <= x_cos + y_sin;
            r_y_out <= x_nsin + y_cos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_x_out     = r_x_out;
    assign o_y_out     = r_y_out;

    `QW_ASSERT(a_empty_takes, i_clk, i_rst_n, !r_s1_valid |-> o_in_ready, "input stage empty but not ready")
    `QW_ASSERT(a_accept_fills, i_clk, i_rst_n, in_accept |=> r_s1_valid, "accepted transaction lost at input stage")
    `QW_ASSERT(a_stage_moves, i_clk, i_rst_n, (r_s1_valid && s1_advance) |=> o_out_valid, "input stage advanced but no result")
    `QW_ASSERT(a_stall_blocks, i_clk, i_rst_n, (r_s1_valid && r_out_valid && !i_out_ready) |-> !o_in_ready, "transaction accepted while full and stalled")

endmodule

`default_nettype wire

/* bench/quarter_wave_vector_rotator_tb.sv */
// Testbench for quarter_wave_vector_rotator: directed table, random vectors, scoreboard
`timescale 1ns / 1ps

module quarter_wave_vector_rotator_tb;
    import qwvr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned HOLD_CYCLES = 300;

    localparam logic [MAG_W-1:0] QUARTER_MAG [0:64] = '{
        8'h00, 8'h06, 8'h0D, 8'h13, 8'h19, 8'h1F, 8'h26, 8'h2C,
        8'h32, 8'h38, 8'h3E, 8'h44, 8'h4A, 8'h50, 8'h56, 8'h5C,
        8'h62, 8'h68, 8'h6D, 8'h73, 8'h79, 8'h7E, 8'h84, 8'h89,
        8'h8E, 8'h93, 8'h98, 8'h9D, 8'hA2, 8'hA7, 8'hAC, 8'hB1,
        8'hB5, 8'hB9, 8'hBE, 8'hC2, 8'hC6, 8'hCA, 8'hCE, 8'hD1,
        8'hD5, 8'hD8, 8'hDC, 8'hDF, 8'hE2, 8'hE5, 8'hE7, 8'hEA,
        8'hED, 8'hEF, 8'hF1, 8'hF3, 8'hF5, 8'hF7, 8'hF8, 8'hFA,
        8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
        8'hFF
    };

    typedef struct packed {
        logic [VEC_W-1:0] x;
        logic [VEC_W-1:0] y;
    } t_rotated;

    typedef struct packed {
        logic               op;
        logic [VEC_W-1:0]   x;
        logic [VEC_W-1:0]   y;
        logic [ANGLE_W-1:0] ang;
        logic               pinned;
        t_rotated           want;
    } t_vector_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic                      i_opcode;
    logic signed [VEC_W-1:0]   i_x_in;
    logic signed [VEC_W-1:0]   i_y_in;
    logic        [ANGLE_W-1:0] i_angle;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [VEC_W-1:0]   o_x_out;
    logic signed [VEC_W-1:0]   o_y_out;

    logic        pinned_valid;
    t_rotated    pinned_vec;
    t_rotated    rotated_q [$];
    t_vector_row directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    bit          hold_req = 1'b0;
    bit          hold_seen = 1'b0;
    int unsigned hold_left = 0;

    quarter_wave_vector_rotator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .i_x_in      (i_x_in),
        .i_y_in      (i_y_in),
        .i_angle     (i_angle),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_x_out     (o_x_out),
        .o_y_out     (o_y_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_trig sine_lookup(input logic [ANGLE_W-1:0] ang);
        t_trig      t;
        logic [6:0] idx;
        idx = ang[6:0];
        if (idx >= 7'h40) begin
            idx = 7'(8'h80 - {1'b0, idx});
        end
        t.mag = QUARTER_MAG[idx];
        t.neg = ang[ANGLE_W-1];
        return t;
    endfunction

    function automatic logic [VEC_W-1:0] scaled_product(input logic [VEC_W-1:0] v,
                                                        input logic [MAG_W-1:0] f,
                                                        input logic fneg);
        logic [VEC_W-1:0] mag;
        logic [31:0]      acc;
        logic [VEC_W-1:0] r;
        mag = v[VEC_W-1] ? (16'd0 - v) : v;
        acc = 32'(mag[15:8]) * 32'(f)
            + ((32'(mag[7:0]) * 32'(f) + 32'(ROUND_HALF)) >> 8);
        r = acc[VEC_W-1:0];
        if (v[VEC_W-1] != fneg) begin
            r = 16'd0 - r;
        end
        return r;
    endfunction

    function automatic t_rotated predict_rotation(input logic op, input logic [VEC_W-1:0] x,
                                                  input logic [VEC_W-1:0] y,
                                                  input logic [ANGLE_W-1:0] ang);
        t_trig    s;
        t_trig    c;
        t_rotated r;
        if (op == OP_ROTATE_NEG) begin
            ang = 8'd0 - ang;
        end
        s = sine_lookup(ang);
        c = sine_lookup(ang + QUARTER_TURN);
        r.x = scaled_product(x, c.mag, c.neg) + scaled_product(y, s.mag, s.neg);
        r.y = scaled_product(x, s.mag, !s.neg) + scaled_product(y, c.mag, c.neg);
        return r;
    endfunction

    function automatic logic [VEC_W-1:0] random_component();
        logic [VEC_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2: v = 16'h0000;
            3: v = 16'hFFFF;
            4: v = 16'($urandom_range(0, 511)) - 16'd256;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [ANGLE_W-1:0] random_angle();
        logic [ANGLE_W-1:0] a;
        if ($urandom_range(0, 3) == 0) begin
            a = {2'($urandom_range(0, 3)), 6'd0} + 8'($urandom_range(0, 2)) - 8'd1;
        end else begin
            a = 8'($urandom);
        end
        return a;
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("quarter_wave_vector_rotator_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : scoreboard
        t_rotated want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (rotated_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected result x=%0d y=%0d", o_x_out, o_y_out);
                    end
                end else begin
                    want = rotated_q.pop_front();
                    if (o_x_out !== want.x || o_y_out !== want.y) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                                     $signed(want.x), $signed(want.y), o_x_out, o_y_out);
                        end
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                rotated_q.push_back(pinned_valid ? pinned_vec
                                    : predict_rotation(i_opcode, i_x_in, i_y_in, i_angle));
            end
        end
    end

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    task automatic offer_vector(input t_vector_row row);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= row.op;
        i_x_in       <= row.x;
        i_y_in       <= row.y;
        i_angle      <= row.ang;
        pinned_valid <= row.pinned;
        pinned_vec   <= row.want;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic offer_random(input int unsigned count);
        t_vector_row row;
        repeat (count) begin
            row.op     = 1'($urandom_range(0, 1));
            row.x      = random_component();
            row.y      = random_component();
            row.ang    = random_angle();
            row.pinned = 1'b0;
            row.want   = '0;
            offer_vector(row);
        end
    endtask

    task automatic drain_rotations();
        i_in_valid <= 1'b0;
        while (rotated_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_ROTATE;
        i_x_in       = '0;
        i_y_in       = '0;
        i_angle      = '0;
        pinned_valid = 1'b0;
        pinned_vec   = '0;

        directed_rows.push_back('{OP_ROTATE,     16'd0,     16'd0,     8'd0,   1'b1,
                                  '{16'd0, 16'd0}});
        directed_rows.push_back('{OP_ROTATE_NEG, 16'd0,     16'd0,     8'd255, 1'b1,
                                  '{16'd0, 16'd0}});
        directed_rows.push_back('{OP_ROTATE,     16'd256,   16'd0,     8'd0,   1'b1,
                                  '{16'd255, 16'd0}});
        directed_rows.push_back('{OP_ROTATE,     16'd256,   16'd0,     8'd64,  1'b1,
                                  '{16'd0, -16'sd255}});
        directed_rows.push_back('{OP_ROTATE_NEG, 16'd256,   16'd0,     8'd64,  1'b1,
                                  '{16'd0, 16'd255}});
        directed_rows.push_back('{OP_ROTATE,     16'h8000,  16'd0,     8'd0,   1'b1,
                                  '{-16'sd32640, 16'd0}});
        directed_rows.push_back('{OP_ROTATE,     16'h8000,  16'd0,     8'd128, 1'b1,
                                  '{16'd32640, 16'd0}});
        directed_rows.push_back('{OP_ROTATE,     16'd0,     16'd256,   8'd0,   1'b1,
                                  '{16'd0, 16'd255}});
        directed_rows.push_back('{OP_ROTATE,     16'd0,     16'h8000,  8'd192, 1'b1,
                                  '{16'd32640, 16'd0}});
        directed_rows.push_back('{OP_ROTATE,     16'h7FFF,  16'h7FFF,  8'd32,  1'b0, '0});
        directed_rows.push_back('{OP_ROTATE_NEG, 16'h8000,  16'h8000,  8'd32,  1'b0, '0});
        directed_rows.push_back('{OP_ROTATE,     16'h7FFF,  16'h8000,  8'd1,   1'b0, '0});
        directed_rows.push_back('{OP_ROTATE_NEG, 16'hFFFF,  16'd1,     8'd63,  1'b0, '0});
        directed_rows.push_back('{OP_ROTATE,     16'h5555,  16'hAAAA,  8'd65,  1'b0, '0});
        directed_rows.push_back('{OP_ROTATE_NEG, 16'hAAAA,  16'h5555,  8'd127, 1'b0, '0});
        directed_rows.push_back('{OP_ROTATE,     16'hFFFF,  16'hFFFF,  8'd129, 1'b0, '0});
        directed_rows.push_back('{OP_ROTATE_NEG, 16'd12345, 16'hFF2E,  8'hAA,  1'b0, '0});
        directed_rows.push_back('{OP_ROTATE,     16'hFED4,  16'd7000,  8'h55,  1'b0, '0});
        directed_rows.push_back('{OP_ROTATE_NEG, 16'h7FFF,  16'd0,     8'd128, 1'b0, '0});
        directed_rows.push_back('{OP_ROTATE,     16'h8000,  16'h7FFF,  8'd255, 1'b0, '0});
        directed_rows.push_back('{OP_ROTATE_NEG, 16'd1,     16'hFFFF,  8'd0,   1'b0, '0});
        directed_rows.push_back('{OP_ROTATE,     16'h00FF,  16'hFF00,  8'd191, 1'b0, '0});

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            offer_vector(directed_rows[i]);
        end
        drain_rotations();

        offer_random(300);
        drain_rotations();

        tx_idle_pct = 88;
        offer_random(230);
        drain_rotations();

        tx_idle_pct  = 0;
        rx_stall_pct = 88;
        offer_random(230);
        drain_rotations();

        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        offer_random(230);
        drain_rotations();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_req     = ~hold_req;
        offer_random(80);
        drain_rotations();

        tx_idle_pct  = 20;
        rx_stall_pct = 20;
        offer_random(60);
        drain_rotations();

        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && rotated_q.size() == 0) begin
            $display("quarter_wave_vector_rotator_tb passed");
        end else begin
            $display("quarter_wave_vector_rotator_tb failed");
        end
        $finish;
    end

endmodule

/* quarter_wave_vector_rotator.f */
+incdir+rtl/core
rtl/core/qwvr_pkg.sv
rtl/core/qwvr_scale.sv
rtl/core/quarter_wave_vector_rotator.sv
bench/quarter_wave_vector_rotator_tb.sv
